/* rtl/core/skeleton_joint_pose_transform_assert.svh */
// Assertion macros for the skeleton joint pose transform block.
`ifndef SKELETON_JOINT_POSE_TRANSFORM_ASSERT_SVH
`define SKELETON_JOINT_POSE_TRANSFORM_ASSERT_SVH

`ifndef SYNTH
`define SJPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SJPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SJPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SJPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/sjpt_pkg.sv */
package sjpt_pkg;

    localparam int MAX_JOINTS     = 64;
    localparam int MAX_FRAMES     = 16;
    localparam int MAX_COMPONENTS = 256;
    localparam int FRAC_BITS      = 16;

    localparam int JOINT_W = 6;
    localparam int FRAME_W = 4;
    localparam int SLOT_W  = 8;
    localparam int FLAG_W  = 6;
    localparam int PAR_W   = 7;
    localparam int DATA_W  = 32;
    localparam int NCH     = 6;
    localparam int NACC    = 12;

    localparam int JT_AW   = $clog2(MAX_JOINTS);
    localparam int POSE_AW = $clog2(MAX_JOINTS * NCH);
    localparam int ACC_AW  = $clog2(MAX_JOINTS * NACC);
    localparam int COMP_AW = $clog2(MAX_FRAMES * MAX_COMPONENTS);

    localparam int PROD_W = 2 * DATA_W;
    localparam int Q_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W  = Q_W + 8;
    localparam int ROOT_W = FRAC_BITS + 1;
    localparam int RAD_W  = 2 * ROOT_W;

    localparam logic signed [SUM_W-1:0]  ONE_Q  = SUM_W'(64'd1 << FRAC_BITS);
    localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(64'd1 << (FRAC_BITS - 1));

    typedef enum logic [1:0] {
        CMD_LOAD_JOINT = 2'd0,
        CMD_LOAD_COMP  = 2'd1,
        CMD_TRANSFORM  = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        Q_XX, Q_YY, Q_ZZ, Q_XY, Q_XZ, Q_YZ, Q_ZW, Q_YW, Q_XW
    } t_qop;

    typedef enum logic [3:0] {
        S_IDLE, S_LDJ, S_POSE, S_CH, S_CHW, S_QM, S_QA, S_SQS, S_SQW,
        S_LOC, S_PRD, S_MMM, S_MMA, S_WR, S_OUT
    } t_state;

    typedef struct packed {
        logic signed [PAR_W-1:0] parent;
        logic [FLAG_W-1:0]       flags;
        logic [SLOT_W-1:0]       start;
    } t_joint_ent;

    // product rounded half up, then scaled down
    function automatic logic signed [Q_W-1:0] qround(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + HALF_Q;
        return Q_W'(s >>> FRAC_BITS);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return DATA_W'(v);
    endfunction

endpackage

/* rtl/core/skeleton_joint_pose_transform.sv */
// Forward kinematics over a joint tree in signed Q16.16. Requests are taken one at a time;
// o_in_stall stays high until the request has finished. A load joint request writes the joint
// table entry and six pose words into a pose memory with one write port and one read port; a
// load component request writes one component word. A transform fetches the pose, applies the
// frame components and forms the quaternion products and the square root; for a child it then
// reads 12 parent-matrix words and forms 36 products on the shared 32x32 multiplier. It
// writes back 12 words and presents 3 result rows, which are held while i_out_stall is high.
// Joints must be transformed parent before child; every entry read must have been loaded.
`include "skeleton_joint_pose_transform_assert.svh"

module skeleton_joint_pose_transform (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_command,
    input  logic [sjpt_pkg::JOINT_W-1:0]       i_joint,
    input  logic signed [sjpt_pkg::PAR_W-1:0]  i_parent,
    input  logic [sjpt_pkg::FLAG_W-1:0]        i_flags,
    input  logic [sjpt_pkg::SLOT_W-1:0]        i_slot,
    input  logic [sjpt_pkg::FRAME_W-1:0]       i_frame,
    input  logic signed [sjpt_pkg::DATA_W-1:0] i_value_x,
    input  logic signed [sjpt_pkg::DATA_W-1:0] i_value_y,
    input  logic signed [sjpt_pkg::DATA_W-1:0] i_value_z,
    input  logic signed [sjpt_pkg::DATA_W-1:0] i_quat_x,
    input  logic signed [sjpt_pkg::DATA_W-1:0] i_quat_y,
    input  logic signed [sjpt_pkg::DATA_W-1:0] i_quat_z,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [sjpt_pkg::JOINT_W-1:0]       o_out_joint,
    output logic [1:0]                         o_row,
    output logic signed [sjpt_pkg::DATA_W-1:0] o_col0,
    output logic signed [sjpt_pkg::DATA_W-1:0] o_col1,
    output logic signed [sjpt_pkg::DATA_W-1:0] o_col2,
    output logic signed [sjpt_pkg::DATA_W-1:0] o_col3,
    output logic                               o_last
);
    import sjpt_pkg::*;

    localparam int SIDX_W = SLOT_W + 1;

    t_joint_ent              m_jt   [MAX_JOINTS];
    logic signed [DATA_W-1:0] m_pose [MAX_JOINTS*NCH];
    logic signed [DATA_W-1:0] m_comp [MAX_FRAMES*MAX_COMPONENTS];
    logic signed [DATA_W-1:0] m_acc  [MAX_JOINTS*NACC];

    t_state                   r_state, n_state;
    logic [3:0]               r_cnt;
    logic [JOINT_W-1:0]       r_jt;
    logic [FRAME_W-1:0]       r_frame;
    t_joint_ent               r_ent;
    logic signed [DATA_W-1:0] r_p   [NCH];
    logic [2:0]               r_ch;
    logic [2:0]               r_j;
    t_qop                     r_op;
    logic signed [Q_W-1:0]    r_q   [9];
    logic signed [ROOT_W:0]   r_w;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_loc [NACC];
    logic signed [DATA_W-1:0] r_pa  [NACC];
    logic signed [DATA_W-1:0] r_acc [NACC];
    logic signed [SUM_W-1:0]  r_s;
    logic [1:0]               r_r, r_c, r_k, r_row;

    t_joint_ent               r_jt_rd;
    logic signed [DATA_W-1:0] r_pose_rd, r_comp_rd, r_acc_rd;

    logic                     in_acc, joint_ok, tx_go, par_ok;
    logic                     jt_we, pose_we, comp_we, acc_we;
    logic [JT_AW-1:0]         jt_ra;
    logic [POSE_AW-1:0]       pose_wa, pose_ra;
    logic [COMP_AW-1:0]       comp_wa, comp_ra;
    logic [ACC_AW-1:0]        acc_wa, acc_ra;
    logic signed [DATA_W-1:0] pose_wd;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic                     sq_start, sq_done;
    logic [ROOT_W-1:0]        sq_root;
    logic [RAD_W-1:0]         sq_rad;
    logic signed [SUM_W-1:0]  t_val, s_new, s_fin;
    logic signed [SUM_W-1:0]  loc_c [NACC];
    logic [SIDX_W-1:0]        cidx_sum, cidx;
    logic [2:0]               pcap;

    function automatic logic [POSE_AW-1:0] pose_addr(input logic [JOINT_W-1:0] jt,
                                                     input logic [3:0] ch);
        return POSE_AW'(jt) * POSE_AW'(NCH) + POSE_AW'(ch);
    endfunction

    function automatic logic [ACC_AW-1:0] acc_addr(input logic [JOINT_W-1:0] jt,
                                                   input logic [3:0] k);
        return ACC_AW'(jt) * ACC_AW'(NACC) + ACC_AW'(k);
    endfunction

    function automatic logic signed [SUM_W-1:0] tw(input logic signed [Q_W-1:0] q);
        return SUM_W'(q) <<< 1;
    endfunction

    assign in_acc   = i_in_valid && !o_in_stall;
    assign joint_ok = int'(i_joint) < MAX_JOINTS;
    assign tx_go    = in_acc && joint_ok && (t_cmd'(i_command) == CMD_TRANSFORM);
    assign par_ok   = !r_ent.parent[PAR_W-1] && (int'(r_ent.parent) < MAX_JOINTS);
    assign pcap     = 3'(r_cnt - 4'd1);

    // component slot wraps over the frame's slots
    assign cidx_sum = SIDX_W'(r_ent.start) + SIDX_W'(r_j);
    assign cidx     = (int'(cidx_sum) >= MAX_COMPONENTS) ?
                      cidx_sum - SIDX_W'(MAX_COMPONENTS) : cidx_sum;

    assign t_val  = ONE_Q - SUM_W'(r_q[Q_XX]) - SUM_W'(r_q[Q_YY]) - SUM_W'(r_q[Q_ZZ]);
    assign sq_rad = RAD_W'(t_val[ROOT_W-1:0]) << FRAC_BITS;

    assign loc_c[0]  = ONE_Q - tw(r_q[Q_YY]) - tw(r_q[Q_ZZ]);
    assign loc_c[1]  = tw(r_q[Q_XY]) + tw(r_q[Q_ZW]);
    assign loc_c[2]  = tw(r_q[Q_XZ]) - tw(r_q[Q_YW]);
    assign loc_c[3]  = SUM_W'(r_p[0]);
    assign loc_c[4]  = tw(r_q[Q_XY]) - tw(r_q[Q_ZW]);
    assign loc_c[5]  = ONE_Q - tw(r_q[Q_XX]) - tw(r_q[Q_ZZ]);
    assign loc_c[6]  = tw(r_q[Q_YZ]) + tw(r_q[Q_XW]);
    assign loc_c[7]  = SUM_W'(r_p[1]);
    assign loc_c[8]  = tw(r_q[Q_XZ]) + tw(r_q[Q_YW]);
    assign loc_c[9]  = tw(r_q[Q_YZ]) - tw(r_q[Q_XW]);
    assign loc_c[10] = ONE_Q - tw(r_q[Q_XX]) - tw(r_q[Q_YY]);
    assign loc_c[11] = SUM_W'(r_p[2]);

    assign s_new = r_s + SUM_W'(qround(r_prod));
    assign s_fin = (r_c == 2'd3) ? s_new + SUM_W'(r_pa[{r_r, 2'd3}]) : s_new;

    sjpt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && joint_ok) begin
                    case (t_cmd'(i_command))
                        CMD_LOAD_JOINT: n_state = S_LDJ;
                        CMD_TRANSFORM:  n_state = S_POSE;
                        default:        n_state = S_IDLE;
                    endcase
                end
            end
            S_LDJ:  if (r_cnt == 4'd5) n_state = S_IDLE;
            S_POSE: if (r_cnt == 4'd6) n_state = S_CH;
            S_CH: begin
                if (r_ch == 3'd6) begin
                    n_state = S_QM;
                end else if (r_ent.flags[r_ch]) begin
                    n_state = S_CHW;
                end
            end
            S_CHW: n_state = S_CH;
            S_QM:  n_state = S_QA;
            S_QA: begin
                if (r_op == Q_YZ) begin
                    n_state = S_SQS;
                end else if (r_op == Q_XW) begin
                    n_state = S_LOC;
                end else begin
                    n_state = S_QM;
                end
            end
            S_SQS: n_state = (t_val <= 0) ? S_QM : S_SQW;
            S_SQW: if (sq_done) n_state = S_QM;
            S_LOC: n_state = par_ok ? S_PRD : S_WR;
            S_PRD: if (r_cnt == 4'd12) n_state = S_MMM;
            S_MMM: n_state = S_MMA;
            S_MMA: begin
                if (r_k == 2'd2 && r_c == 2'd3 && r_r == 2'd2) begin
                    n_state = S_WR;
                end else begin
                    n_state = S_MMM;
                end
            end
            S_WR:  if (r_cnt == 4'd11) n_state = S_OUT;
            S_OUT: if (!i_out_stall && r_row == 2'd2) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_OUT);
        jt_we    = 1'b0;
        pose_we  = 1'b0;
        comp_we  = 1'b0;
        acc_we   = 1'b0;
        sq_start = 1'b0;
        jt_ra    = (r_state == S_IDLE) ? i_joint[JT_AW-1:0] : r_jt[JT_AW-1:0];
        pose_wa  = pose_addr(r_jt, r_cnt);
        pose_wd  = r_p[r_cnt[2:0]];
        pose_ra  = pose_addr(r_jt, r_cnt);
        comp_wa  = COMP_AW'(i_frame) * COMP_AW'(MAX_COMPONENTS) + COMP_AW'(i_slot);
        comp_ra  = COMP_AW'(r_frame) * COMP_AW'(MAX_COMPONENTS) + COMP_AW'(cidx);
        acc_wa   = acc_addr(r_jt, r_cnt);
        acc_ra   = acc_addr(r_ent.parent[JOINT_W-1:0], r_cnt);
        mul_a    = r_pa[{r_r, r_k}];
        mul_b    = r_loc[{r_k, r_c}];
        case (r_state)
            S_IDLE: begin
                if (in_acc && joint_ok && t_cmd'(i_command) == CMD_LOAD_JOINT) begin
                    jt_we = 1'b1;
                end
                if (in_acc && t_cmd'(i_command) == CMD_LOAD_COMP &&
                    int'(i_slot) < MAX_COMPONENTS && int'(i_frame) < MAX_FRAMES) begin
                    comp_we = 1'b1;
                end
            end
            S_LDJ: pose_we = 1'b1;
            S_CHW: begin
                pose_we = 1'b1;
                pose_wa = pose_addr(r_jt, {1'b0, r_ch});
                pose_wd = r_comp_rd;
            end
            S_QM: begin
                case (r_op)
                    Q_XX: begin mul_a = r_p[3]; mul_b = r_p[3]; end
                    Q_YY: begin mul_a = r_p[4]; mul_b = r_p[4]; end
                    Q_ZZ: begin mul_a = r_p[5]; mul_b = r_p[5]; end
                    Q_XY: begin mul_a = r_p[3]; mul_b = r_p[4]; end
                    Q_XZ: begin mul_a = r_p[3]; mul_b = r_p[5]; end
                    Q_YZ: begin mul_a = r_p[4]; mul_b = r_p[5]; end
                    Q_ZW: begin mul_a = r_p[5]; mul_b = DATA_W'(r_w); end
                    Q_YW: begin mul_a = r_p[4]; mul_b = DATA_W'(r_w); end
                    Q_XW: begin mul_a = r_p[3]; mul_b = DATA_W'(r_w); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_SQS: sq_start = (t_val > 0);
            S_WR:  acc_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (jt_we) begin
            m_jt[i_joint[JT_AW-1:0]] <= '{parent: i_parent, flags: i_flags, start: i_slot};
        end
        r_jt_rd <= m_jt[jt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pose_we) begin
            m_pose[pose_wa] <= pose_wd;
        end
        r_pose_rd <= m_pose[pose_ra];
    end

    always_ff @(posedge i_clk) begin
        if (comp_we) begin
            m_comp[comp_wa] <= i_value_x;
        end
        r_comp_rd <= m_comp[comp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            m_acc[acc_wa] <= r_acc[r_cnt];
        end
        r_acc_rd <= m_acc[acc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cnt   <= '0;
                r_jt    <= i_joint;
                r_frame <= i_frame;
                r_p[0]  <= i_value_x;
                r_p[1]  <= i_value_y;
                r_p[2]  <= i_value_z;
                r_p[3]  <= i_quat_x;
                r_p[4]  <= i_quat_y;
                r_p[5]  <= i_quat_z;
            end
            S_LDJ: r_cnt <= r_cnt + 4'd1;
            S_POSE: begin
                if (r_cnt == 4'd0) begin
                    r_ent <= r_jt_rd;
                end else begin
                    r_p[pcap] <= r_pose_rd;
                end
                r_cnt <= r_cnt + 4'd1;
                r_ch  <= '0;
                r_j   <= '0;
            end
            S_CH: begin
                if (r_ch != 3'd6 && !r_ent.flags[r_ch]) begin
                    r_ch <= r_ch + 3'd1;
                end
                r_op <= Q_XX;
            end
            S_CHW: begin
                r_p[r_ch] <= r_comp_rd;
                r_ch <= r_ch + 3'd1;
                r_j  <= r_j + 3'd1;
            end
            S_QM: r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
            S_QA: begin
                r_q[r_op] <= qround(r_prod);
                r_op <= t_qop'(r_op + 4'd1);
            end
            S_SQS: r_w <= '0;
            S_SQW: begin
                if (sq_done) begin
                    r_w <= -$signed({1'b0, sq_root});
                end
            end
            S_LOC: begin
                for (int i = 0; i < NACC; i++) begin
                    r_loc[i] <= sat32(loc_c[i]);
                    r_acc[i] <= sat32(loc_c[i]);
                end
                r_cnt <= '0;
            end
            S_PRD: begin
                if (r_cnt != 4'd0) begin
                    r_pa[r_cnt - 4'd1] <= r_acc_rd;
                end
                if (r_cnt == 4'd12) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 4'd1;
                end
                r_r <= '0;
                r_c <= '0;
                r_k <= '0;
                r_s <= '0;
            end
            S_MMM: r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
            S_MMA: begin
                if (r_k == 2'd2) begin
                    r_acc[{r_r, r_c}] <= sat32(s_fin);
                    r_s <= '0;
                    r_k <= '0;
                    r_c <= r_c + 2'd1;
                    if (r_c == 2'd3) begin
                        r_r <= r_r + 2'd1;
                    end
                end else begin
                    r_s <= s_new;
                    r_k <= r_k + 2'd1;
                end
                r_cnt <= '0;
            end
            S_WR: begin
                r_cnt <= r_cnt + 4'd1;
                r_row <= '0;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    r_row <= r_row + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_joint = r_jt;
    assign o_row       = r_row;
    assign o_col0      = r_acc[{r_row, 2'd0}];
    assign o_col1      = r_acc[{r_row, 2'd1}];
    assign o_col2      = r_acc[{r_row, 2'd2}];
    assign o_col3      = r_acc[{r_row, 2'd3}];
    assign o_last      = (r_row == 2'd2);

    `SJPT_ASSERT_IMPLY(a_out_blocks_in, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `SJPT_ASSERT_NEXT(a_tx_busy, i_clk, i_rst_n, tx_go, o_in_stall && !o_out_valid)
    `SJPT_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_last, !o_out_valid && !o_in_stall)
    `SJPT_ASSERT_IMPLY(a_sqrt_waited, i_clk, i_rst_n, sq_done, r_state == S_SQW)

endmodule

/* rtl/core/sjpt_sqrt.sv */
module sjpt_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sjpt_pkg::RAD_W-1:0]   i_rad,
    output logic                         o_done,
    output logic [sjpt_pkg::ROOT_W-1:0]  o_root
);
    import sjpt_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W-1:0]  rem2;
    logic [REM_W-1:0]  trial;

    assign rem2  = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial = REM_W'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= r_rad << 2;
            if (rem2 >= trial) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
